### hw/rtl/amav_pkg.sv
// ----------------------------------------------------------------------------
// amav_pkg - shared types and constants of the accelerometer moving average
// Window depth, sample and sum widths, axis codes and the result formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package amav_pkg;

  // Window depth per axis (legal range 2 to 64)
  localparam int WINDOW   = 10;
  localparam int NUM_AXES = 3;

  // Axis codes
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 20;
  localparam int SLOT_W   = $clog2(WINDOW);
  // Running sum holds +/- WINDOW * 2^15 and its negation
  localparam int SUM_W    = SAMPLE_W + 1 + $clog2(WINDOW);
  localparam int EXT_W    = (SUM_W > OUT_W) ? SUM_W : OUT_W;

  localparam int OUT_MAX = (2 ** (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(2 ** (OUT_W - 1));

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [NUM_AXES-1:0]     samples_t;
  typedef logic signed [SUM_W-1:0]    acc_t;
  typedef logic signed [OUT_W-1:0]    result_t;
  typedef result_t [NUM_AXES-1:0]     results_t;
  typedef logic [SLOT_W-1:0]          slot_t;

  // Control passed from the top level to the window and the accumulator
  typedef struct packed {
    logic load;   // item moves from the input register into the result register
    logic prime;  // first item after reset: fill the whole window
  } amav_ctl_t;

  // X and Y are reported negated, Z as is
  function automatic logic axis_negated(input int axis);
    return (axis != AXIS_Z);
  endfunction

  // Negate on request, then clamp to the result field
  function automatic result_t format_sum(input acc_t sum, input logic neg);
    logic signed [EXT_W-1:0] ext;
    logic signed [EXT_W-1:0] max_e;
    logic signed [EXT_W-1:0] min_e;
    ext   = EXT_W'(sum);
    max_e = EXT_W'(OUT_MAX);
    min_e = EXT_W'(OUT_MIN);
    if (neg) begin
      ext = -ext;
    end
    if (ext > max_e) begin
      ext = max_e;
    end else if (ext < min_e) begin
      ext = min_e;
    end
    return OUT_W'(ext);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/accel_moving_average_3axis_unit.sv
// An accepted sample is held in the input register, then passes through the
// combinational running-sum update into the result register, where out_valid rises.
// Throughput: one sample per cycle while out_ready is high.
// Reset: synchronous active-low rst_n clears the handshake state, the ring pointer
// and the primed flag; window entries are not reset, the first sample after reset
// fills the whole window.
// ----------------------------------------------------------------------------
// accel_moving_average_3axis_unit - three-axis accelerometer moving average
// Input register, window and running-sum logic, and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_moving_average_3axis_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [amav_pkg::SAMPLE_W-1:0] in_accel_x,
  input  wire logic signed [amav_pkg::SAMPLE_W-1:0] in_accel_y,
  input  wire logic signed [amav_pkg::SAMPLE_W-1:0] in_accel_z,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [amav_pkg::OUT_W-1:0]      out_sum_x,
  output logic signed [amav_pkg::OUT_W-1:0]      out_sum_y,
  output logic signed [amav_pkg::OUT_W-1:0]      out_sum_z
);

  logic                in_valid_r;
  logic                in_valid_nxt;
  amav_pkg::samples_t  in_samp_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  amav_pkg::results_t  out_res_r;
  amav_pkg::results_t  result;
  amav_pkg::samples_t  oldest;
  logic                primed;
  logic                load;
  logic                in_xfer;
  amav_pkg::amav_ctl_t ctl;

  // Move the held item on when the result register is free or being drained
  assign load     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || load;
  assign in_xfer  = in_valid && in_ready;

  assign ctl.load  = load;
  assign ctl.prime = !primed;

  // Input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (load) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_samp_r[amav_pkg::AXIS_X] <= in_accel_x;
      in_samp_r[amav_pkg::AXIS_Y] <= in_accel_y;
      in_samp_r[amav_pkg::AXIS_Z] <= in_accel_z;
    end
  end

  amav_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .samp   (in_samp_r),
    .oldest (oldest),
    .primed (primed)
  );

  amav_accum u_accum (
    .clk    (clk),
    .ctl    (ctl),
    .samp   (in_samp_r),
    .oldest (oldest),
    .result (result)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sum_x = out_res_r[amav_pkg::AXIS_X];
  assign out_sum_y = out_res_r[amav_pkg::AXIS_Y];
  assign out_sum_z = out_res_r[amav_pkg::AXIS_Z];

  // Checks
  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("result register not valid after a load");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !load) |=> in_valid_r)
    else $error("held input item dropped without a load");

  a_prime_once: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !ctl.prime)
    else $error("window still unprimed after a load");

  a_load_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_valid_r) |=> in_valid_r)
    else $error("accepted item not held in the input register");

endmodule

`default_nettype wire

### hw/rtl/amav_window.sv
// ----------------------------------------------------------------------------
// amav_window - sample window and ring pointer for three axes
// Holds WINDOW samples per axis, provides the entry about to be replaced and
// writes the new sample (or all entries on the first sample after reset).
// ----------------------------------------------------------------------------
`default_nettype none

module amav_window (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire amav_pkg::amav_ctl_t ctl,
  input  wire amav_pkg::samples_t  samp,
  output amav_pkg::samples_t       oldest,
  output logic                     primed
);

  localparam amav_pkg::slot_t LAST_SLOT = amav_pkg::SLOT_W'(amav_pkg::WINDOW - 1);

  amav_pkg::slot_t slot_r;
  amav_pkg::slot_t slot_nxt;
  amav_pkg::slot_t rd_slot;
  logic            primed_r;
  logic            primed_nxt;

  // Treat an out-of-range pointer as entry zero
  always_comb begin
    if (int'(slot_r) >= amav_pkg::WINDOW) begin
      rd_slot = '0;
    end else begin
      rd_slot = slot_r;
    end
  end

  // Advance the ring pointer; priming leaves it at zero
  always_comb begin
    slot_nxt   = slot_r;
    primed_nxt = primed_r;
    if (ctl.load) begin
      primed_nxt = 1'b1;
      if (ctl.prime || (rd_slot == LAST_SLOT)) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = rd_slot + amav_pkg::slot_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      primed_r <= 1'b0;
    end else begin
      slot_r   <= slot_nxt;
      primed_r <= primed_nxt;
    end
  end

  // Window storage, one register row per axis
  for (genvar a = 0; a < amav_pkg::NUM_AXES; a++) begin : g_axis
    amav_pkg::sample_t win_r [amav_pkg::WINDOW];

    for (genvar e = 0; e < amav_pkg::WINDOW; e++) begin : g_entry
      always_ff @(posedge clk) begin
        if (ctl.load && (ctl.prime || (rd_slot == amav_pkg::SLOT_W'(e)))) begin
          win_r[e] <= samp[a];
        end
      end
    end

    assign oldest[a] = win_r[rd_slot];
  end

  assign primed = primed_r;

endmodule

`default_nettype wire

### hw/rtl/amav_accum.sv
// ----------------------------------------------------------------------------
// amav_accum - running window sums for three axes
// Adds the new sample and drops the replaced one, or loads WINDOW times the
// sample on priming; presents the formatted next sums for the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module amav_accum (
  input  wire logic                clk,
  input  wire amav_pkg::amav_ctl_t ctl,
  input  wire amav_pkg::samples_t  samp,
  input  wire amav_pkg::samples_t  oldest,
  output amav_pkg::results_t       result
);

  localparam amav_pkg::acc_t WIN_S = amav_pkg::SUM_W'(amav_pkg::WINDOW);

  for (genvar a = 0; a < amav_pkg::NUM_AXES; a++) begin : g_axis
    amav_pkg::acc_t sum_r;
    amav_pkg::acc_t sum_nxt;
    amav_pkg::acc_t new_ext;
    amav_pkg::acc_t old_ext;

    assign new_ext = amav_pkg::SUM_W'($signed(samp[a]));
    assign old_ext = amav_pkg::SUM_W'($signed(oldest[a]));

    // Prime with WINDOW copies, else slide the window by one sample
    always_comb begin
      if (ctl.prime) begin
        sum_nxt = new_ext * WIN_S;
      end else begin
        sum_nxt = sum_r + new_ext - old_ext;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load) begin
        sum_r <= sum_nxt;
      end
    end

    assign result[a] = amav_pkg::format_sum(sum_nxt, amav_pkg::axis_negated(a));
  end

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the three-axis accelerometer moving average
// Streams directed and random samples through the unit under varied sender and
// receiver idling, predicts each window sum in-line and checks every transfer.
// ----------------------------------------------------------------------------
module tb;
  import amav_pkg::*;

  // Idling profiles applied per stimulus segment
  typedef enum int unsigned {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE
  } idle_phase_t;

  typedef struct {
    sample_t     ax;
    sample_t     ay;
    sample_t     az;
    idle_phase_t phase;
    bit          hold;
  } sample_item_t;

  typedef struct {
    result_t sx;
    result_t sy;
    result_t sz;
  } sum_triple_t;

  localparam int RANDOM_ITEMS = 850;
  localparam int SEGMENT_LEN  = 50;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_TIME   = 2000000;

  logic    clk        = 1'b0;
  logic    rst_n      = 1'b0;
  logic    in_valid   = 1'b0;
  logic    in_ready;
  sample_t in_accel_x = '0;
  sample_t in_accel_y = '0;
  sample_t in_accel_z = '0;
  logic    out_valid;
  logic    out_ready  = 1'b0;
  result_t out_sum_x;
  result_t out_sum_y;
  result_t out_sum_z;

  sample_item_t stim_q[$];
  sum_triple_t  sums_due[$];
  int           fail_count = 0;
  logic         in_took    = 1'b0;
  logic         hold_kick  = 1'b0;
  int           hold_left  = 0;
  idle_phase_t  cur_phase  = PH_STEADY;

  // Predictor state: per-axis sample history and running sums
  sample_t     hist[NUM_AXES][WINDOW];
  longint      run_sum[NUM_AXES];
  int unsigned ring_slot = 0;
  bit          filled    = 1'b0;

  accel_moving_average_3axis_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sum_x  (out_sum_x),
    .out_sum_y  (out_sum_y),
    .out_sum_z  (out_sum_z)
  );

  always #5 clk = ~clk;

  // Clamp a window sum to the signed result field
  function automatic result_t clamp_sum(input longint v);
    if (v > longint'(OUT_MAX)) begin
      return result_t'(OUT_MAX);
    end else if (v < longint'(OUT_MIN)) begin
      return result_t'(OUT_MIN);
    end
    return result_t'(v);
  endfunction

  // Advance the window by one sample and return the expected sums
  function automatic sum_triple_t advance_window(input sample_t ax, input sample_t ay,
                                                 input sample_t az);
    sample_t     smp[NUM_AXES];
    sum_triple_t r;
    int unsigned s;
    smp[AXIS_X] = ax;
    smp[AXIS_Y] = ay;
    smp[AXIS_Z] = az;
    if (!filled) begin
      // First sample after reset fills the whole window
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int i = 0; i < WINDOW; i++) begin
          hist[a][i] = smp[a];
        end
        run_sum[a] = longint'(smp[a]) * WINDOW;
      end
      filled    = 1'b1;
      ring_slot = 0;
    end else begin
      s = (ring_slot >= WINDOW) ? 0 : ring_slot;
      for (int a = 0; a < NUM_AXES; a++) begin
        run_sum[a] += longint'(smp[a]) - longint'(hist[a][s]);
        hist[a][s] = smp[a];
      end
      s++;
      ring_slot = (s >= WINDOW) ? 0 : s;
    end
    r.sx = clamp_sum(-run_sum[AXIS_X]);
    r.sy = clamp_sum(-run_sum[AXIS_Y]);
    r.sz = clamp_sum(run_sum[AXIS_Z]);
    return r;
  endfunction

  // Percentage of cycles a side idles under a given profile
  function automatic int unsigned idle_pct(input idle_phase_t ph, input bit sender);
    if (ph == PH_BOTH_IDLE) begin
      return 22;
    end else if ((sender && ph == PH_SEND_IDLE) || (!sender && ph == PH_RECV_STALL)) begin
      return 67;
    end
    return 0;
  endfunction

  // Mix of extremes, near-zero values and full-range noise
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        return sample_t'(16'h7FFF);
      end
      1: begin
        return sample_t'(16'h8000);
      end
      2: begin
        return sample_t'(int'($urandom_range(0, 16)) - 8);
      end
      default: begin
        return sample_t'($urandom());
      end
    endcase
  endfunction

  task automatic queue_sample(input sample_t ax, input sample_t ay, input sample_t az,
                              input idle_phase_t ph, input bit hold);
    sample_item_t it;
    it.ax    = ax;
    it.ay    = ay;
    it.az    = az;
    it.phase = ph;
    it.hold  = hold;
    stim_q.push_back(it);
  endtask

  task automatic check_field(input string name, input result_t want, input result_t got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Sender: launch the next queued sample once the previous one has transferred
  always @(negedge clk) begin : sender
    sample_item_t nxt;
    bit           kick;
    kick = 1'b0;
    if (rst_n && (!in_valid || in_took)) begin
      if (stim_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(stim_q[0].phase, 1'b1))
      begin
        nxt        = stim_q.pop_front();
        in_accel_x <= nxt.ax;
        in_accel_y <= nxt.ay;
        in_accel_z <= nxt.az;
        in_valid   <= 1'b1;
        cur_phase  <= nxt.phase;
        kick       = nxt.hold;
      end else begin
        in_valid <= 1'b0;
      end
    end
    hold_kick <= kick;
  end

  // Receiver: random stalls, plus a long hold-off when the sender requests one
  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct(cur_phase, 1'b0));
    end
  end

  // Monitor: check result transfers, then predict accepted samples
  always @(posedge clk) begin : monitor
    sum_triple_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (sums_due.size() == 0) begin
          $display("%0t: result with none pending, expected none actual %0d %0d %0d",
                   $time, out_sum_x, out_sum_y, out_sum_z);
          fail_count++;
        end else begin
          want = sums_due.pop_front();
          check_field("sum_x", want.sx, out_sum_x);
          check_field("sum_y", want.sy, out_sum_y);
          check_field("sum_z", want.sz, out_sum_z);
        end
      end
      if (in_valid && in_ready) begin
        sums_due.push_back(advance_window(in_accel_x, in_accel_y, in_accel_z));
      end
    end
  end

  initial begin : main
    int          n;
    int          run_len;
    int          holds;
    bit          hold_now;
    idle_phase_t ph;
    sample_t     cx;
    sample_t     cy;
    sample_t     cz;

    // Directed: prime with extremes, fill the ring with the opposite extremes, wrap
    queue_sample(sample_t'(16'h8000), sample_t'(16'h7FFF), sample_t'(16'h8000),
                 PH_STEADY, 1'b0);
    for (int i = 0; i < WINDOW; i++) begin
      queue_sample(sample_t'(16'h7FFF), sample_t'(16'h8000), sample_t'(16'h7FFF),
                   PH_STEADY, 1'b0);
    end
    queue_sample(sample_t'(0), sample_t'(-1), sample_t'(1), PH_STEADY, 1'b0);
    queue_sample(sample_t'(16'h5555), sample_t'(16'hAAAA), sample_t'(16'h8000),
                 PH_STEADY, 1'b0);
    queue_sample(sample_t'(16'hAAAA), sample_t'(16'h5555), sample_t'(16'h7FFF),
                 PH_STEADY, 1'b0);
    queue_sample(sample_t'(-1), sample_t'(0), sample_t'(-1), PH_STEADY, 1'b0);

    // Random: rotate idling profiles by segment, with runs of repeated values
    n     = 0;
    holds = 0;
    while (n < RANDOM_ITEMS) begin
      ph = idle_phase_t'((n / SEGMENT_LEN) % 4);
      if ($urandom_range(0, 7) == 0) begin
        run_len = $urandom_range(WINDOW, WINDOW + 2);
        cx      = pick_sample();
        cy      = pick_sample();
        cz      = pick_sample();
        for (int i = 0; i < run_len; i++) begin
          queue_sample(cx, cy, cz, ph, 1'b0);
        end
        n += run_len;
      end else begin
        // Long receiver hold-off twice during steady segments
        hold_now = ((holds == 0) && (n >= 5)) ||
                   ((holds == 1) && (n >= 4 * SEGMENT_LEN * 2 + 7));
        if (hold_now) begin
          holds++;
        end
        queue_sample(pick_sample(), pick_sample(), pick_sample(), ph, hold_now);
        n++;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (sums_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("accel_moving_average_3axis_unit: match");
    end else begin
      $display("accel_moving_average_3axis_unit: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(LIMIT_TIME);
    $display("accel_moving_average_3axis_unit: mismatch");
    $finish;
  end

endmodule
